// ===== src/sortable_record_queue_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sortable record queue
// Shorthand for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef SORTABLE_RECORD_QUEUE_CORE_MACROS_SVH
`define SORTABLE_RECORD_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SRQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sortable record queue check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SRQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sortable record queue check failed");

`endif

// ===== src/srq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sortable record queue package
// Shared sizes, record layout, request and status codes, and cell controls.
// ----------------------------------------------------------------------------
package srq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int TAG_W  = 16;
    localparam int NAME_W = 32;
    localparam int AGE_W  = 8;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 2;

    typedef struct packed {
        logic [AGE_W-1:0]  age;
        logic [NAME_W-1:0] name;
        logic [TAG_W-1:0]  tag;
    } t_rec;

    typedef enum logic [2:0] {
        REQ_APPEND = 3'd0,
        REQ_REMOVE = 3'd1,
        REQ_SEARCH = 3'd2,
        REQ_SORT   = 3'd3,
        REQ_LIST   = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Operation that every cell of the row performs.
    typedef enum logic [2:0] {
        OP_HOLD   = 3'd0,
        OP_APPEND = 3'd1,
        OP_SHIFT  = 3'd2,
        OP_ROTATE = 3'd3,
        OP_SORT   = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic             parity;
        logic [CNT_W-1:0] occ;
        t_rec             rec;
    } t_cell_ctl;

    typedef struct packed {
        t_status status;
        logic    last;
        t_rec    rec;
    } t_result;

endpackage

// ===== src/srq_cell.sv =====
// ----------------------------------------------------------------------------
// Sortable record queue cell
// One queue slot: holds a record and trades it with its neighbors.
// ----------------------------------------------------------------------------
module srq_cell (
    input  logic                     i_clk,
    input  logic [srq_pkg::CNT_W-1:0] i_index,
    input  srq_pkg::t_cell_ctl       i_ctl,
    input  srq_pkg::t_rec            i_left,
    input  srq_pkg::t_rec            i_right,
    input  srq_pkg::t_rec            i_head,
    output srq_pkg::t_rec            o_rec
);
    import srq_pkg::*;

    t_rec             r_rec;
    t_rec             n_rec;
    logic [CNT_W-1:0] w_next_index;
    logic             w_pair_left;
    logic             w_pair_right;

    assign w_next_index = i_index + CNT_W'(1);

    // In a sort phase, a cell pairs with its right neighbor when its index
    // parity matches the phase, and with its left neighbor otherwise.
    assign w_pair_left  = (i_index[0] == i_ctl.parity) && (w_next_index < i_ctl.occ);
    assign w_pair_right = (i_index[0] != i_ctl.parity) && (i_index != '0)
                          && (i_index < i_ctl.occ);

    always_comb begin
        n_rec = r_rec;
        unique case (i_ctl.op)
            OP_HOLD: begin
                n_rec = r_rec;
            end
            OP_APPEND: begin
                if (i_index == i_ctl.occ) begin
                    n_rec = i_ctl.rec;
                end
            end
            OP_SHIFT: begin
                n_rec = i_right;
            end
            OP_ROTATE: begin
                if (w_next_index == i_ctl.occ) begin
                    n_rec = i_head;
                end else begin
                    n_rec = i_right;
                end
            end
            OP_SORT: begin
                if (w_pair_left && (r_rec.age > i_right.age)) begin
                    n_rec = i_right;
                end else if (w_pair_right && (i_left.age > r_rec.age)) begin
                    n_rec = i_left;
                end
            end
            default: begin
                n_rec = r_rec;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec = r_rec;

endmodule

// ===== src/sortable_record_queue_core.sv =====
// ----------------------------------------------------------------------------
// Sortable record queue core
// Bounded record queue with append, remove, search, stable sort and list.
// ----------------------------------------------------------------------------
// The queue is a row of QUEUE_DEPTH cells, head in cell 0, each holding one
// record and exchanging it with its neighbors. Append, remove and requests of
// an unknown type finish as they are accepted. A search is accepted and then
// rotates the row past the head cell one slot per cycle, the final rotation
// waiting for room in the output register; the row is back in its original
// order when it finishes. A sort likewise is accepted and then runs one
// odd-even transposition phase per cycle over adjacent cells, one phase per
// record, the final phase waiting for room in the output register, and
// leaves records of equal age in their original order. A list is accepted,
// then rotates one slot per cycle while the result side takes its results and
// sends one result per record. Results leave through an output register, so a
// new request can be taken in the same cycle a waiting result is taken.
// Requests are taken only between multi-cycle operations. An empty queue
// answers a search or list at once, and a queue with fewer than two records
// answers a sort at once.
// ----------------------------------------------------------------------------
module sortable_record_queue_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request channel.
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata: record_tag[15:0], name_key[47:16], age[55:48].
    input  logic [srq_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: req_type[2:0].
    input  logic [srq_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    // Result channel.
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // tdata: out_tag[15:0], out_name[47:16], out_age[55:48].
    output logic [srq_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // tuser: status[1:0].
    output logic [srq_pkg::M_TUSER_W-1:0] o_m_axis_tuser,
    // tlast: last_result.
    output logic                          o_m_axis_tlast
);
    import srq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_SORT   = 4'b0100,
        S_LIST   = 4'b1000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_occ;
    logic [CNT_W-1:0]  n_occ;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [NAME_W-1:0] r_key;
    logic [NAME_W-1:0] n_key;
    logic              r_found;
    logic              n_found;
    t_rec              r_hit;
    t_rec              n_hit;
    logic              r_out_valid;
    logic              n_out_valid;
    t_result           r_out;
    t_result           n_out;

    t_cell_ctl         w_ctl;
    t_rec              w_rec [QUEUE_DEPTH];
    t_rec              w_in_rec;
    t_req              w_req;
    logic              w_accept;
    logic              w_out_free;
    logic              w_at_end;
    logic              w_hit_now;

    // The cell row. Cells at the two ends see an all-zero neighbor.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_rec w_left;
        t_rec w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_l
            assign w_left = w_rec[g-1];
        end
        if (g == QUEUE_DEPTH - 1) begin : g_final
            assign w_right = '0;
        end else begin : g_inner_r
            assign w_right = w_rec[g+1];
        end
        srq_cell u_cell (
            .i_clk   (i_clk),
            .i_index (CNT_W'(g)),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_rec[0]),
            .o_rec   (w_rec[g])
        );
    end

    assign w_in_rec.tag  = i_s_axis_tdata[15:0];
    assign w_in_rec.name = i_s_axis_tdata[47:16];
    assign w_in_rec.age  = i_s_axis_tdata[55:48];
    assign w_req         = t_req'(i_s_axis_tuser[2:0]);

    // The output register is free when empty or being emptied this cycle.
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // The multi-cycle operations step once per record; this marks the final step.
    assign w_at_end  = (r_cnt == (r_occ - CNT_W'(1)));
    assign w_hit_now = !r_found && (w_rec[0].name == r_key);

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_cnt       = r_cnt;
        n_key       = r_key;
        n_found     = r_found;
        n_hit       = r_hit;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out       = r_out;

        w_ctl.op     = OP_HOLD;
        w_ctl.parity = r_cnt[0];
        w_ctl.occ    = r_occ;
        w_ctl.rec    = w_in_rec;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cnt = '0;
                    unique case (w_req)
                        REQ_APPEND: begin
                            n_out_valid = 1'b1;
                            n_out       = '{status: ST_OK, last: 1'b1, rec: '0};
                            if (r_occ == CNT_W'(QUEUE_DEPTH)) begin
                                n_out.status = ST_FULL;
                            end else begin
                                w_ctl.op = OP_APPEND;
                                n_occ    = r_occ + CNT_W'(1);
                            end
                        end
                        REQ_REMOVE: begin
                            n_out_valid = 1'b1;
                            if (r_occ == '0) begin
                                n_out = '{status: ST_EMPTY, last: 1'b1, rec: '0};
                            end else begin
                                n_out    = '{status: ST_OK, last: 1'b1, rec: w_rec[0]};
                                w_ctl.op = OP_SHIFT;
                                n_occ    = r_occ - CNT_W'(1);
                            end
                        end
                        REQ_SEARCH: begin
                            if (r_occ == '0) begin
                                n_out_valid = 1'b1;
                                n_out = '{status: ST_EMPTY, last: 1'b1, rec: '0};
                            end else begin
                                n_key   = w_in_rec.name;
                                n_found = 1'b0;
                                n_state = S_SEARCH;
                            end
                        end
                        REQ_SORT: begin
                            if (r_occ < CNT_W'(2)) begin
                                n_out_valid = 1'b1;
                                n_out = '{status: ST_OK, last: 1'b1, rec: '0};
                            end else begin
                                n_state = S_SORT;
                            end
                        end
                        REQ_LIST: begin
                            if (r_occ == '0) begin
                                n_out_valid = 1'b1;
                                n_out = '{status: ST_EMPTY, last: 1'b1, rec: '0};
                            end else begin
                                n_state = S_LIST;
                            end
                        end
                        default: begin
                            // Unknown request types are dropped without a result.
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                // The final rotation waits for the output register so that the
                // row and the result complete together.
                if (!w_at_end || w_out_free) begin
                    w_ctl.op = OP_ROTATE;
                    n_cnt    = r_cnt + CNT_W'(1);
                    if (w_hit_now) begin
                        n_found = 1'b1;
                        n_hit   = w_rec[0];
                    end
                    if (w_at_end) begin
                        n_out_valid = 1'b1;
                        if (r_found) begin
                            n_out = '{status: ST_OK, last: 1'b1, rec: r_hit};
                        end else if (w_hit_now) begin
                            n_out = '{status: ST_OK, last: 1'b1, rec: w_rec[0]};
                        end else begin
                            n_out = '{status: ST_NOTFOUND, last: 1'b1, rec: '0};
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            S_SORT: begin
                if (!w_at_end || w_out_free) begin
                    w_ctl.op = OP_SORT;
                    n_cnt    = r_cnt + CNT_W'(1);
                    if (w_at_end) begin
                        n_out_valid = 1'b1;
                        n_out       = '{status: ST_OK, last: 1'b1, rec: '0};
                        n_state     = S_IDLE;
                    end
                end
            end
            S_LIST: begin
                // One record leaves the head per accepted result slot.
                if (w_out_free) begin
                    w_ctl.op    = OP_ROTATE;
                    n_cnt       = r_cnt + CNT_W'(1);
                    n_out_valid = 1'b1;
                    n_out       = '{status: ST_OK, last: w_at_end, rec: w_rec[0]};
                    if (w_at_end) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_cnt       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_cnt       <= n_cnt;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_hit <= n_hit;
        r_out <= n_out;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.rec.age, r_out.rec.name, r_out.rec.tag};
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tlast  = r_out.last;

endmodule

// ===== src/srq_chk.sv =====
// ----------------------------------------------------------------------------
// Sortable record queue checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "sortable_record_queue_core_macros.svh"

module srq_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_axis_tready,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [srq_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input logic [srq_pkg::M_TUSER_W-1:0] o_m_axis_tuser,
    input logic                          o_m_axis_tlast
);
    import srq_pkg::*;

    logic                           w_stall;
    logic [M_TDATA_W+M_TUSER_W:0]   w_payload;

    assign w_stall   = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_payload = {o_m_axis_tlast, o_m_axis_tuser, o_m_axis_tdata};

    // A stalled result keeps its whole payload.
    `SRQ_ASSERT_NEXT(a_out_hold, w_stall, o_m_axis_tvalid && $stable(w_payload))

    // Any result that is not a success ends its request.
    `SRQ_ASSERT_NOW(a_err_last, o_m_axis_tvalid && (o_m_axis_tuser != ST_OK), o_m_axis_tlast)

    // A result that is not a success carries no record.
    `SRQ_ASSERT_NOW(a_err_zero, o_m_axis_tvalid && (o_m_axis_tuser != ST_OK), o_m_axis_tdata == '0)

    // Requests are taken only when the result register can take a new result.
    `SRQ_ASSERT_NOW(a_ready_room, o_s_axis_tready, !o_m_axis_tvalid || i_m_axis_tready)

endmodule

bind sortable_record_queue_core srq_chk u_srq_chk (.*);
